// ===== src/assert_macros.svh =====
// assertion helpers for the filter rtl
// each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== src/cidf_pkg.sv =====
`default_nettype none

package cidf_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // identifier field layout
    localparam int ID_W       = 29;
    localparam int PRIO_SHIFT = 26;
    localparam int PRIO_W     = 3;
    localparam int ARB_SHIFT  = 13;
    localparam int FIELD_W    = 13;
    localparam int PAYLOAD_W  = 64;
    localparam int LEN_W      = 4;
    localparam int NUM_BYTES  = PAYLOAD_W / 8;

    // result status codes
    typedef enum logic [2:0] {
        STATUS_FORWARDED = 3'd0,
        STATUS_LEARNED   = 3'd1,
        STATUS_KNOWN     = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_CLEARED   = 3'd4
    } status_t;

    // item action codes
    typedef enum logic {
        ACTION_FRAME = 1'b0,
        ACTION_CLEAR = 1'b1
    } action_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LAST,
        ST_RESOLVE
    } state_t;

    // input item
    typedef struct packed {
        action_t                action;
        logic [ID_W-1:0]        frame_id;
        logic [LEN_W-1:0]       data_len;
        logic [PAYLOAD_W-1:0]   payload;
    } in_item_t;

    // result item
    typedef struct packed {
        status_t                status;
        logic [PRIO_W-1:0]      priority_res;
        logic [FIELD_W-1:0]     arbitration;
        logic [FIELD_W-1:0]     sender;
        logic [ID_W-1:0]        out_id;
        logic [LEN_W-1:0]       out_len;
        logic [PAYLOAD_W-1:0]   out_payload;
        logic [COUNT_W-1:0]     entry_count;
    } out_item_t;

    // sequencer to table requests
    typedef struct packed {
        logic                   rd_en;
        logic [IDX_W-1:0]       rd_addr;
        logic                   wr_en;
        logic [IDX_W-1:0]       wr_addr;
        logic [ID_W-1:0]        wr_data;
        logic [ID_W-1:0]        key;
    } tbl_req_t;

endpackage

`default_nettype wire

// ===== src/cidf_table.sv =====
`default_nettype none

module cidf_table
    import cidf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire tbl_req_t req,
    output logic          hit
);

    logic [ID_W-1:0] mem [TABLE_DEPTH];
    logic [ID_W-1:0] rdata_reg;
    logic            valid_reg;

    // identifier storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    // marks read data that belongs to a read issued last cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= req.rd_en;
        end
    end

    // shared identifier compare
    assign hit = valid_reg && (rdata_reg == req.key);

endmodule

`default_nettype wire

// ===== src/can_id_learning_filter.sv =====
// can identifier filter with learning
//
// item channel: an item is taken at a rising edge with start high and busy
// low. a frame item looks its identifier up in the learned table; a clear
// item empties the table.
// result channel: each item gives exactly one result, shown on result for
// one cycle while done is high. the receiver cannot stall, so the result
// must be captured in that cycle.
// config: cfg_we writes cfg_wdata into learn_mode; write only while idle.
// sequence: a clear item gives its result in the cycle after it is taken. a frame
// item scans the table one entry per cycle through the single read port of
// the table memory and one shared comparator; after the last entry it passes
// through ST_LAST and ST_RESOLVE (an empty table goes straight to ST_RESOLVE),
// and it ends sooner when an entry matches. busy drops in the cycle that shows
// the result; no new item is taken before that.
// reset: the table becomes empty and learn_mode returns to pass mode; the
// table contents are not cleared, only the entry count.
`default_nettype none
`include "assert_macros.svh"

module can_id_learning_filter
    import cidf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire in_item_t  item,
    output logic           done,
    output out_item_t      result,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata
);

    state_t               state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [COUNT_W-1:0]   idx_reg, idx_next;
    logic                 learn_mode_reg;
    logic                 done_reg, done_next;
    out_item_t            result_reg, result_next;
    tbl_req_t             tbl_req;
    logic                 hit;
    logic [COUNT_W-1:0]   count_inc;

    // keeps the bytes of data below len, all eight when len is above seven
    function automatic logic [PAYLOAD_W-1:0] valid_bytes(
        input logic [PAYLOAD_W-1:0] data,
        input logic [LEN_W-1:0]     len
    );
        logic [PAYLOAD_W-1:0] keep;
        keep = '0;
        for (int b = 0; b < NUM_BYTES; b++)
        begin
            if (len > LEN_W'(b))
            begin
                keep[b*8 +: 8] = 8'hFF;
            end
        end
        return data & keep;
    endfunction

    cidf_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .hit   (hit)
    );

    assign count_inc = count_reg + COUNT_W'(1);

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            done_reg       <= 1'b0;
            learn_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                learn_mode_reg <= cfg_wdata;
            end
        end
    end

    // item and result holding registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        result_reg <= result_next;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        tbl_req         = '0;
        tbl_req.key     = item_reg.frame_id;
        tbl_req.rd_addr = idx_reg[IDX_W-1:0];
        tbl_req.wr_addr = count_reg[IDX_W-1:0];
        tbl_req.wr_data = item_reg.frame_id;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    idx_next  = '0;
                    if (item.action == ACTION_CLEAR)
                    begin
                        count_next         = '0;
                        result_next        = '0;
                        result_next.status = STATUS_CLEARED;
                        done_next          = 1'b1;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_RESOLVE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end

            // issue one read per cycle, compare the one issued before
            ST_SEARCH:
            begin
                tbl_req.rd_en = 1'b1;
                idx_next      = idx_reg + COUNT_W'(1);
                if (hit)
                begin
                    result_next             = '0;
                    result_next.status      = STATUS_KNOWN;
                    result_next.out_id      = item_reg.frame_id;
                    result_next.entry_count = count_reg;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else if (idx_next == count_reg)
                begin
                    state_next = ST_LAST;
                end
            end

            // compare the last entry read
            ST_LAST:
            begin
                if (hit)
                begin
                    result_next             = '0;
                    result_next.status      = STATUS_KNOWN;
                    result_next.out_id      = item_reg.frame_id;
                    result_next.entry_count = count_reg;
                    done_next               = 1'b1;
                    state_next              = ST_IDLE;
                end
                else
                begin
                    state_next = ST_RESOLVE;
                end
            end

            // unknown identifier: learn, report full, or forward
            ST_RESOLVE:
            begin
                result_next        = '0;
                result_next.out_id = item_reg.frame_id;
                done_next          = 1'b1;
                state_next         = ST_IDLE;
                if (learn_mode_reg)
                begin
                    if (count_reg < COUNT_W'(TABLE_DEPTH))
                    begin
                        tbl_req.wr_en           = 1'b1;
                        count_next              = count_inc;
                        result_next.status      = STATUS_LEARNED;
                        result_next.entry_count = count_inc;
                    end
                    else
                    begin
                        result_next.status      = STATUS_FULL;
                        result_next.entry_count = count_reg;
                    end
                end
                else
                begin
                    result_next.status       = STATUS_FORWARDED;
                    result_next.priority_res =
                        item_reg.frame_id[PRIO_SHIFT +: PRIO_W];
                    result_next.arbitration  =
                        item_reg.frame_id[ARB_SHIFT +: FIELD_W];
                    result_next.sender       = item_reg.frame_id[FIELD_W-1:0];
                    result_next.out_len      = item_reg.data_len;
                    result_next.out_payload  =
                        valid_bytes(item_reg.payload, item_reg.data_len);
                    result_next.entry_count  = count_reg;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // checks
    `ASSERT_IMPL(a_done_idle, done_reg, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_count_bound, 1'b1, count_reg <= COUNT_W'(TABLE_DEPTH))
    `ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_reg)
    `ASSERT_IMPL(a_learn_grows, done_reg && result_reg.status == STATUS_LEARNED,
        count_reg == $past(count_reg) + COUNT_W'(1))

endmodule

`default_nettype wire

// ===== tb/sv/id_filter_checker.sv =====
`timescale 1ns / 1ps

module id_filter_checker
    import cidf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      busy,
    input  wire in_item_t  item,
    input  wire logic      done,
    input  wire out_item_t result,
    input  wire logic      cfg_we,
    input  wire logic      cfg_wdata,
    output int             fail_count,
    output int             pending
);

    localparam int MAX_REPORTS = 10;

    // shadow copy of the learned table and the mode register
    logic [ID_W-1:0] learned_ids [TABLE_DEPTH];
    int              learned_count;
    logic            learn_mode;
    out_item_t       expected_verdicts [$];
    out_item_t       want;

    // verdict for one item, updating the shadow table
    function automatic out_item_t filter_frame(in_item_t it);
        out_item_t r;
        logic      hit;
        r = '0;
        hit = 1'b0;
        r.out_id = it.frame_id;
        if (it.action == ACTION_CLEAR)
        begin
            learned_count = 0;
            r.status = STATUS_CLEARED;
            r.out_id = '0;
        end
        else
        begin
            for (int i = 0; i < learned_count; i++)
                if (learned_ids[i] == it.frame_id)
                    hit = 1'b1;
            if (hit)
            begin
                r.status = STATUS_KNOWN;
            end
            else if (learn_mode)
            begin
                if (learned_count < TABLE_DEPTH)
                begin
                    learned_ids[learned_count] = it.frame_id;
                    learned_count++;
                    r.status = STATUS_LEARNED;
                end
                else
                begin
                    r.status = STATUS_FULL;
                end
            end
            else
            begin
                // unknown in pass mode: split the identifier, keep valid bytes
                r.status = STATUS_FORWARDED;
                r.priority_res = it.frame_id[ID_W-1 -: PRIO_W];
                r.arbitration = it.frame_id[PRIO_SHIFT-1 -: FIELD_W];
                r.sender = it.frame_id[FIELD_W-1:0];
                r.out_len = it.data_len;
                if (it.data_len >= NUM_BYTES)
                    r.out_payload = it.payload;
                else
                    r.out_payload = it.payload & ((64'd1 << (it.data_len * 8)) - 64'd1);
            end
        end
        r.entry_count = COUNT_W'(learned_count);
        return r;
    endfunction

    function automatic string verdict_text(out_item_t r);
        return $sformatf("status %0d prio %0d arb %h sender %h id %h len %0d data %h count %0d",
                         r.status, r.priority_res, r.arbitration, r.sender, r.out_id,
                         r.out_len, r.out_payload, r.entry_count);
    endfunction

    initial
    begin
        fail_count = 0;
        pending = 0;
        learned_count = 0;
        learn_mode = 1'b0;
    end

    // track config, compare results, predict accepted items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learned_count = 0;
            learn_mode = 1'b0;
            expected_verdicts.delete();
        end
        else
        begin
            if (cfg_we)
                learn_mode = cfg_wdata;
            if (done)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("unexpected result at %0t: %s", $time, verdict_text(result));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (result !== want)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                        begin
                            $display("result mismatch at %0t", $time);
                            $display("  expected %s", verdict_text(want));
                            $display("  actual   %s", verdict_text(result));
                        end
                    end
                end
            end
            if (start && !busy)
                expected_verdicts.insert(expected_verdicts.size(), filter_frame(item));
        end
        pending = expected_verdicts.size();
    end

endmodule

// ===== tb/sv/can_id_learning_filter_test.sv =====
`timescale 1ns / 1ps

module can_id_learning_filter_test;
    import cidf_pkg::*;

    localparam int STIM_ITEMS     = 2000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RECENT_DEPTH   = 48;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    in_item_t  item = '0;
    logic      done;
    out_item_t result;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;
    int        fail_count;
    int        pending;
    int        items_sent = 0;
    int        stalled_cycles = 0;
    int        burst_left = 0;
    logic [ID_W-1:0] recent_ids [$];

    always #5 clk = ~clk;

    can_id_learning_filter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    id_filter_checker verdict_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // frame with random id, length (mostly legal) and payload
    function automatic in_item_t random_frame();
        in_item_t it;
        it.action = ACTION_FRAME;
        it.frame_id = ID_W'($urandom());
        if ($urandom_range(0, 5) == 0)
            it.data_len = LEN_W'($urandom_range(9, 15));
        else
            it.data_len = LEN_W'($urandom_range(0, 8));
        it.payload = {$urandom(), $urandom()};
        return it;
    endfunction

    function automatic in_item_t frame_item(logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                                            logic [PAYLOAD_W-1:0] data);
        in_item_t it;
        it.action = ACTION_FRAME;
        it.frame_id = id;
        it.data_len = len;
        it.payload = data;
        return it;
    endfunction

    // clear item, other fields random
    function automatic in_item_t clear_item();
        in_item_t it;
        it = random_frame();
        it.action = ACTION_CLEAR;
        return it;
    endfunction

    // hand one item over, then keep the burst going or idle a while
    task automatic send_item(in_item_t it);
        @(negedge clk);
        start = 1'b1;
        item = it;
        do @(posedge clk); while (busy);
        items_sent++;
        if (it.action == ACTION_FRAME)
        begin
            recent_ids.insert(recent_ids.size(), it.frame_id);
            if (recent_ids.size() > RECENT_DEPTH)
                void'(recent_ids.pop_front());
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            @(negedge clk);
            start = 1'b0;
            item = random_frame();
            item.action = action_t'($urandom_range(0, 1));
            repeat ($urandom_range(0, 44)) @(negedge clk);
            burst_left = $urandom_range(0, 11);
        end
    endtask

    // hold off until every outstanding item has its result
    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_learn_mode(logic mode);
        drain_results();
        cfg_we = 1'b1;
        cfg_wdata = mode;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // stimulus and verdict
    initial
    begin
        in_item_t it;
        int       pick;
        logic     phase_learn;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // pass mode: identifier, length and payload extremes
        write_learn_mode(1'b0);
        send_item(frame_item('0, 4'd0, '1));
        send_item(frame_item('1, 4'd8, '1));
        send_item(frame_item(29'h0AAA_AAAA, 4'd3, 64'h0123_4567_89AB_CDEF));
        send_item(frame_item(29'h1555_5555, 4'd15, 64'hFEDC_BA98_7654_3210));
        send_item(frame_item(29'h1C00_2001, 4'd9, '1));
        send_item(frame_item(29'h03FF_E000, 4'd1, '1));
        send_item(frame_item(29'h0000_1FFF, 4'd7, '1));

        // learn mode: learn, known repeat, clear, relearn
        write_learn_mode(1'b1);
        send_item(frame_item('0, 4'd2, '1));
        send_item(frame_item('1, 4'd8, '1));
        send_item(frame_item('0, 4'd8, '1));
        send_item(clear_item());
        send_item(frame_item('0, 4'd5, '1));
        send_item(frame_item(29'h0123_4567, 4'd4, '0));

        // pass mode: known suppressed, unknown forwarded, clear, then forwarded
        write_learn_mode(1'b0);
        send_item(frame_item(29'h0123_4567, 4'd8, '1));
        send_item(frame_item('1, 4'd6, '1));
        send_item(clear_item());
        send_item(frame_item(29'h0123_4567, 4'd8, '1));

        // random phases, each in one mode; learn phases only clear at their start
        while (items_sent < STIM_ITEMS)
        begin
            phase_learn = 1'($urandom_range(0, 1));
            write_learn_mode(phase_learn);
            if ($urandom_range(0, 3) == 0)
                send_item(clear_item());
            repeat ($urandom_range(20, 70))
            begin
                pick = $urandom_range(0, 99);
                it = random_frame();
                if (pick < 3 && !phase_learn)
                    it.action = ACTION_CLEAR;
                else if (pick < 35 && recent_ids.size() > 0)
                    it.frame_id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
                else if (pick < 40)
                    it.frame_id = pick[0] ? '1 : '0;
                send_item(it);
            end
        end

        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog on cycles with no item and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule
